// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define SRS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define SRS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: rtl/core/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Types and constants shared by the reconvergence stack modules.
// ----------------------------------------------------------------------------
`default_nettype none

package srs_pkg;

   localparam int FIELD_W     = 32;
   localparam int ACTION_W    = 3;
   localparam int IDX_W       = 5;
   localparam int STATUS_W    = 2;
   localparam int DEPTH_OUT_W = 6;
   localparam int LANE_COUNT  = 32;
   localparam int LANE_CMP_W  = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [ACTION_W-1:0] {
      ACT_PUSH  = 3'd0,
      ACT_POP   = 3'd1,
      ACT_PEEK  = 3'd2,
      ACT_READ  = 3'd3,
      ACT_CHECK = 3'd4,
      ACT_CLEAR = 3'd5
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_OVERFLOW = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_RANGE    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_NOP   = 3'd0,
      OP_PUSH  = 3'd1,
      OP_POP   = 3'd2,
      OP_PEEK  = 3'd3,
      OP_READ  = 3'd4,
      OP_CHECK = 3'd5,
      OP_CLEAR = 3'd6
   } op_kind_type;

   typedef enum logic {
      BK_IDLE = 1'b0,
      BK_EXEC = 1'b1
   } back_state_type;

   typedef struct packed {
      logic [FIELD_W-1:0] br_pc;
      logic [FIELD_W-1:0] reconv_pc;
      logic [FIELD_W-1:0] lane_mask;
      logic [FIELD_W-1:0] ret_pc;
   } frame_type;

   typedef struct packed {
      op_kind_type        kind;
      frame_type          frame;
      logic [IDX_W-1:0]   read_index;
      logic               lane_in_warp;
      logic [IDX_W-1:0]   lane_index;
      logic [FIELD_W-1:0] lane_pc;
      logic               lane_exited;
      logic               last_lane;
   } op_type;

   typedef struct packed {
      status_type             status;
      frame_type              frame;
      logic [DEPTH_OUT_W-1:0] depth;
      logic                   empty;
      logic                   converged;
      logic                   popped;
   } res_type;

endpackage

`default_nettype wire

// File: rtl/core/simt_reconvergence_stack_unit.sv
// ----------------------------------------------------------------------------
// simt_reconvergence_stack_unit
// Divergence stack for one SIMT warp: push, pop, peek, indexed read, clear
// and streamed per-lane convergence checks.
// ----------------------------------------------------------------------------
// Each request transaction gives exactly one response. Requests are decoded
// into a two-entry queue, so the request side keeps flowing while the
// executor works. For each transaction the executor first reads the top
// (or indexed) entry from the registered stack memory, then evaluates and
// updates the stack count; it takes the next transaction only once the
// current one is done, and it waits while the response side stalls.
// The stack memory is not cleared; only entries below the current depth
// are ever delivered, and all of them were pushed.
`default_nettype none

module simt_reconvergence_stack_unit #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [srs_pkg::ACTION_W-1:0]      req_action,
   input  wire logic [srs_pkg::FIELD_W-1:0]       req_entry_branch_pc,
   input  wire logic [srs_pkg::FIELD_W-1:0]       req_entry_reconv_pc,
   input  wire logic [srs_pkg::FIELD_W-1:0]       req_entry_active_mask,
   input  wire logic [srs_pkg::FIELD_W-1:0]       req_entry_return_pc,
   input  wire logic [srs_pkg::IDX_W-1:0]         req_read_index,
   input  wire logic [srs_pkg::IDX_W-1:0]         req_lane_index,
   input  wire logic [srs_pkg::FIELD_W-1:0]       req_lane_pc,
   input  wire logic                              req_lane_exited,
   input  wire logic                              req_last_lane,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [srs_pkg::STATUS_W-1:0]           rsp_status,
   output logic [srs_pkg::FIELD_W-1:0]            rsp_out_branch_pc,
   output logic [srs_pkg::FIELD_W-1:0]            rsp_out_reconv_pc,
   output logic [srs_pkg::FIELD_W-1:0]            rsp_out_active_mask,
   output logic [srs_pkg::FIELD_W-1:0]            rsp_out_return_pc,
   output logic [srs_pkg::DEPTH_OUT_W-1:0]        rsp_stack_depth,
   output logic                                   rsp_stack_empty,
   output logic                                   rsp_converged,
   output logic                                   rsp_popped_on_converge
);

   logic            q_full, q_push, q_pop, q_valid;
   srs_pkg::op_type q_in_item, q_out_item;

   srs_front u_front (
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_entry_branch_pc   (req_entry_branch_pc),
      .req_entry_reconv_pc   (req_entry_reconv_pc),
      .req_entry_active_mask (req_entry_active_mask),
      .req_entry_return_pc   (req_entry_return_pc),
      .req_read_index        (req_read_index),
      .req_lane_index        (req_lane_index),
      .req_lane_pc           (req_lane_pc),
      .req_lane_exited       (req_lane_exited),
      .req_last_lane         (req_last_lane),
      .q_full                (q_full),
      .q_push                (q_push),
      .q_item                (q_in_item)
   );

   srs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_in_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .item      (q_out_item)
   );

   srs_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock                  (clock),
      .reset                  (reset),
      .q_valid                (q_valid),
      .q_item                 (q_out_item),
      .q_pop                  (q_pop),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_status             (rsp_status),
      .rsp_out_branch_pc      (rsp_out_branch_pc),
      .rsp_out_reconv_pc      (rsp_out_reconv_pc),
      .rsp_out_active_mask    (rsp_out_active_mask),
      .rsp_out_return_pc      (rsp_out_return_pc),
      .rsp_stack_depth        (rsp_stack_depth),
      .rsp_stack_empty        (rsp_stack_empty),
      .rsp_converged          (rsp_converged),
      .rsp_popped_on_converge (rsp_popped_on_converge)
   );

endmodule

`default_nettype wire

// File: rtl/core/srs_front.sv
// ----------------------------------------------------------------------------
// srs_front
// Accepts request transactions and decodes them into queue operations.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_front (
   input  wire logic                         req_valid,
   output logic                              req_stall,
   input  wire logic [srs_pkg::ACTION_W-1:0] req_action,
   input  wire logic [srs_pkg::FIELD_W-1:0]  req_entry_branch_pc,
   input  wire logic [srs_pkg::FIELD_W-1:0]  req_entry_reconv_pc,
   input  wire logic [srs_pkg::FIELD_W-1:0]  req_entry_active_mask,
   input  wire logic [srs_pkg::FIELD_W-1:0]  req_entry_return_pc,
   input  wire logic [srs_pkg::IDX_W-1:0]    req_read_index,
   input  wire logic [srs_pkg::IDX_W-1:0]    req_lane_index,
   input  wire logic [srs_pkg::FIELD_W-1:0]  req_lane_pc,
   input  wire logic                         req_lane_exited,
   input  wire logic                         req_last_lane,
   input  wire logic                         q_full,
   output logic                              q_push,
   output srs_pkg::op_type                   q_item
);

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_item                 = '0;
      q_item.frame.br_pc     = req_entry_branch_pc;
      q_item.frame.reconv_pc = req_entry_reconv_pc;
      q_item.frame.lane_mask = req_entry_active_mask;
      q_item.frame.ret_pc    = req_entry_return_pc;
      q_item.read_index      = req_read_index;
      q_item.lane_index      = req_lane_index;
      q_item.lane_pc         = req_lane_pc;
      q_item.lane_exited     = req_lane_exited;
      q_item.last_lane       = req_last_lane;
      // lanes beyond the warp never count as mismatches
      q_item.lane_in_warp = {1'b0, req_lane_index} <
                            srs_pkg::LANE_CMP_W'(srs_pkg::LANE_COUNT);
      case (req_action)
         srs_pkg::ACT_PUSH:  q_item.kind = srs_pkg::OP_PUSH;
         srs_pkg::ACT_POP:   q_item.kind = srs_pkg::OP_POP;
         srs_pkg::ACT_PEEK:  q_item.kind = srs_pkg::OP_PEEK;
         srs_pkg::ACT_READ:  q_item.kind = srs_pkg::OP_READ;
         srs_pkg::ACT_CHECK: q_item.kind = srs_pkg::OP_CHECK;
         srs_pkg::ACT_CLEAR: q_item.kind = srs_pkg::OP_CLEAR;
         default:            q_item.kind = srs_pkg::OP_NOP;
      endcase
   end

endmodule

`default_nettype wire

// File: rtl/core/srs_queue.sv
// ----------------------------------------------------------------------------
// srs_queue
// Small FIFO of decoded operations between the front end and the executor.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_queue (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire srs_pkg::op_type push_item,
   output logic                 full,
   input  wire logic            pop,
   output logic                 valid,
   output srs_pkg::op_type      item
);

   srs_pkg::op_type                 slot_ff [srs_pkg::QUEUE_DEPTH];
   logic [srs_pkg::QPTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [srs_pkg::QPTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [srs_pkg::QCNT_W-1:0]      count_ff, count_in;

   assign full  = count_ff == srs_pkg::QCNT_W'(srs_pkg::QUEUE_DEPTH);
   assign valid = count_ff != '0;
   assign item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/srs_back.sv
// ----------------------------------------------------------------------------
// srs_back
// Executes queued operations against the stack memory and registers results.
// ----------------------------------------------------------------------------
`default_nettype none

module srs_back #(
   parameter int STACK_DEPTH = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   input  wire srs_pkg::op_type                 q_item,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [srs_pkg::STATUS_W-1:0]         rsp_status,
   output logic [srs_pkg::FIELD_W-1:0]          rsp_out_branch_pc,
   output logic [srs_pkg::FIELD_W-1:0]          rsp_out_reconv_pc,
   output logic [srs_pkg::FIELD_W-1:0]          rsp_out_active_mask,
   output logic [srs_pkg::FIELD_W-1:0]          rsp_out_return_pc,
   output logic [srs_pkg::DEPTH_OUT_W-1:0]      rsp_stack_depth,
   output logic                                 rsp_stack_empty,
   output logic                                 rsp_converged,
   output logic                                 rsp_popped_on_converge
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int XW = (CW > srs_pkg::IDX_W) ? CW : srs_pkg::IDX_W;

   srs_pkg::frame_type        stack_mem_ff [STACK_DEPTH];
   srs_pkg::frame_type        top_ff;
   srs_pkg::op_type           op_ff;
   srs_pkg::back_state_type   state_ff, state_in;
   srs_pkg::res_type          res_ff, res_in;

   logic [CW-1:0] count_ff, count_in, count_dec;
   logic          mismatch_ff, mismatch_in;
   logic          rsp_valid_ff;
   logic          out_free, done, wr_en, lane_hit, mismatch_now;
   logic [XW-1:0] q_ridx_x, op_ridx_x, count_x;
   logic [AW-1:0] rd_addr;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign count_dec = count_ff - CW'(1);
   assign count_x   = XW'(count_ff);
   assign q_ridx_x  = XW'(q_item.read_index);
   assign op_ridx_x = XW'(op_ff.read_index);
   assign rd_addr   = (q_item.kind == srs_pkg::OP_READ) ? q_ridx_x[AW-1:0]
                                                        : count_dec[AW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srs_pkg::BK_IDLE: if (q_valid) state_in = srs_pkg::BK_EXEC;
         srs_pkg::BK_EXEC: if (out_free) state_in = srs_pkg::BK_IDLE;
         default:          state_in = srs_pkg::BK_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop = 1'b0;
      done  = 1'b0;
      case (state_ff)
         srs_pkg::BK_IDLE: q_pop = q_valid;
         srs_pkg::BK_EXEC: done  = out_free;
         default: begin
            q_pop = 1'b0;
            done  = 1'b0;
         end
      endcase
   end

   // execute the held operation; top_ff holds the top or indexed entry
   always_comb begin
      res_in       = '0;
      res_in.status = srs_pkg::ST_OK;
      count_in     = count_ff;
      mismatch_in  = mismatch_ff;
      wr_en        = 1'b0;
      lane_hit     = (count_ff != '0) && op_ff.lane_in_warp &&
                     top_ff.lane_mask[op_ff.lane_index] && !op_ff.lane_exited &&
                     (op_ff.lane_pc != top_ff.reconv_pc);
      mismatch_now = mismatch_ff || lane_hit;
      case (op_ff.kind)
         srs_pkg::OP_PUSH: begin
            if (count_ff >= CW'(STACK_DEPTH)) begin
               res_in.status = srs_pkg::ST_OVERFLOW;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         srs_pkg::OP_POP, srs_pkg::OP_PEEK: begin
            if (count_ff == '0) begin
               res_in.status = srs_pkg::ST_EMPTY;
            end else begin
               res_in.frame = top_ff;
               if (op_ff.kind == srs_pkg::OP_POP) count_in = count_dec;
            end
         end
         srs_pkg::OP_READ: begin
            if (op_ridx_x >= count_x) begin
               res_in.status = srs_pkg::ST_RANGE;
            end else begin
               res_in.frame = top_ff;
            end
         end
         srs_pkg::OP_CHECK: begin
            mismatch_in = mismatch_now;
            if (op_ff.last_lane) begin
               mismatch_in = 1'b0;
               if (count_ff == '0) begin
                  res_in.converged = 1'b1;
               end else if (!mismatch_now) begin
                  res_in.converged = 1'b1;
                  res_in.popped    = 1'b1;
                  res_in.frame     = top_ff;
                  count_in         = count_dec;
               end
            end
         end
         srs_pkg::OP_CLEAR: begin
            count_in    = '0;
            mismatch_in = 1'b0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      res_in.depth = srs_pkg::DEPTH_OUT_W'(count_in);
      res_in.empty = count_in == '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srs_pkg::BK_IDLE;
         count_ff     <= '0;
         mismatch_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (done) begin
            count_ff    <= count_in;
            mismatch_ff <= mismatch_in;
         end
         if (done) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff  <= q_item;
         top_ff <= stack_mem_ff[rd_addr];
      end
      if (done) begin
         res_ff <= res_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done && wr_en) begin
         stack_mem_ff[count_ff[AW-1:0]] <= op_ff.frame;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_status             = res_ff.status;
   assign rsp_out_branch_pc      = res_ff.frame.br_pc;
   assign rsp_out_reconv_pc      = res_ff.frame.reconv_pc;
   assign rsp_out_active_mask    = res_ff.frame.lane_mask;
   assign rsp_out_return_pc      = res_ff.frame.ret_pc;
   assign rsp_stack_depth        = res_ff.depth;
   assign rsp_stack_empty        = res_ff.empty;
   assign rsp_converged          = res_ff.converged;
   assign rsp_popped_on_converge = res_ff.popped;

endmodule

`default_nettype wire

// File: rtl/core/srs_checker.sv
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks on the reconvergence stack response channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module srs_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_stall,
   input wire logic [srs_pkg::STATUS_W-1:0]      rsp_status,
   input wire logic [srs_pkg::FIELD_W-1:0]       rsp_out_branch_pc,
   input wire logic [srs_pkg::FIELD_W-1:0]       rsp_out_active_mask,
   input wire logic [srs_pkg::DEPTH_OUT_W-1:0]   rsp_stack_depth,
   input wire logic                              rsp_stack_empty,
   input wire logic                              rsp_converged,
   input wire logic                              rsp_popped_on_converge
);

   `SRS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `SRS_ASSERT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_status) && $stable(rsp_out_branch_pc) && $stable(rsp_stack_depth))
   `SRS_ASSERT(a_depth_empty, clock, reset, rsp_valid && (rsp_stack_depth != '0) |-> !rsp_stack_empty)
   `SRS_ASSERT(a_pop_conv, clock, reset, rsp_valid && rsp_popped_on_converge |-> rsp_converged && (rsp_status == srs_pkg::ST_OK))
   `SRS_ASSERT(a_err_clean, clock, reset, rsp_valid && (rsp_status != srs_pkg::ST_OK) |-> !rsp_converged && (rsp_out_active_mask == '0))

endmodule

bind simt_reconvergence_stack_unit srs_checker u_srs_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_status             (rsp_status),
   .rsp_out_branch_pc      (rsp_out_branch_pc),
   .rsp_out_active_mask    (rsp_out_active_mask),
   .rsp_stack_depth        (rsp_stack_depth),
   .rsp_stack_empty        (rsp_stack_empty),
   .rsp_converged          (rsp_converged),
   .rsp_popped_on_converge (rsp_popped_on_converge)
);

`default_nettype wire
